FILE: hdl/crc16_length_stamp_generator_assert.svh
// assertion macros shared by the crc16 length stamp checker
`ifndef CRC16_LENGTH_STAMP_GENERATOR_ASSERT_SVH
`define CRC16_LENGTH_STAMP_GENERATOR_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define CSG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("csg assertion failed");

// condition in one cycle implies a condition in the next cycle
`define CSG_ASSERT_NEXT(label, cause, effect) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error("csg assertion failed");

`endif

FILE: hdl/csg_pkg.sv
// shared constants, types and functions of the crc16 length stamp generator
package csg_pkg;

    localparam int DataW      = 8;
    localparam int CharW      = 7;
    localparam int CrcW       = 16;
    localparam int CountW     = 16;
    localparam int NibbleW    = 4;
    localparam int StampChars = 8;
    localparam int IdxW       = $clog2(StampChars);

    localparam logic [CrcW-1:0]   CrcPoly  = 16'hA001;
    localparam logic [CrcW-1:0]   CrcInit  = '0;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [CharW-1:0]  CharZero = 7'h30;
    localparam logic [CharW-1:0]  CharA    = 7'h41;

    // finished message sums handed to the stamp serializer
    typedef struct packed {
        logic              load;
        logic [CrcW-1:0]   crc;
        logic [CountW-1:0] count;
    } t_stamp_load;

    // one byte of reflected crc-16, lsb first, unrolled over the eight bits
    function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0] crc,
                                                 input logic [DataW-1:0] data);
        logic [CrcW-1:0] c;
        logic            fb;
        c = crc;
        for (int k = 0; k < DataW; k++) begin
            fb = c[0] ^ data[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CrcPoly;
            end
        end
        return c;
    endfunction

    // uppercase ascii hex digit of a nibble
    function automatic logic [CharW-1:0] hex_char(input logic [NibbleW-1:0] nib);
        logic [CharW-1:0] wide;
        wide = {{(CharW-NibbleW){1'b0}}, nib};
        if (nib < NibbleW'(10)) begin
            return CharZero + wide;
        end
        return CharA + wide - CharW'(10);
    endfunction

endpackage

FILE: hdl/csg_if.sv
// valid/ready channel interfaces for message bytes and stamp characters
interface csg_in_if import csg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DataW-1:0] data_byte;
    logic             end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface csg_out_if import csg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CharW-1:0]  stamp_char;
    logic              last_of_stamp;
    logic [CrcW-1:0]   crc_value;
    logic [CountW-1:0] byte_count;

    modport source (output valid, output stamp_char, output last_of_stamp,
                    output crc_value, output byte_count, input ready);
    modport sink   (input valid, input stamp_char, input last_of_stamp,
                    input crc_value, input byte_count, output ready);
endinterface

FILE: hdl/csg_crc_acc.sv
// input register with running crc-16 and saturating byte count
module csg_crc_acc import csg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    csg_in_if.sink      i_in,
    input  logic        i_can_load,
    output t_stamp_load o_load
);

    logic              r_valid;
    logic [DataW-1:0]  r_data;
    logic              r_eom;
    logic [CrcW-1:0]   r_crc;
    logic [CountW-1:0] r_count;

    logic [CrcW-1:0]   n_crc;
    logic [CountW-1:0] n_count;
    logic              consume;

    // fold the registered byte into the sums
    always_comb begin
        n_crc   = crc_byte(r_crc, r_data);
        n_count = (r_count == CountMax) ? r_count : r_count + CountW'(1);
    end

    // a final byte waits until the serializer can take the stamp
    assign consume     = r_valid && (!r_eom || i_can_load);
    assign i_in.ready  = !r_valid || consume;

    assign o_load.load  = r_valid && r_eom && i_can_load;
    assign o_load.crc   = n_crc;
    assign o_load.count = n_count;

    // control and running sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_crc   <= CrcInit;
            r_count <= '0;
        end else begin
            if (i_in.ready) begin
                r_valid <= i_in.valid;
            end
            if (consume) begin
                if (r_eom) begin
                    r_crc   <= CrcInit;
                    r_count <= '0;
                end else begin
                    r_crc   <= n_crc;
                    r_count <= n_count;
                end
            end
        end
    end

    // byte payload of the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_data <= i_in.data_byte;
            r_eom  <= i_in.end_of_message;
        end
    end

endmodule

FILE: hdl/csg_stamp_ser.sv
// turns crc and count into eight ascii hex characters sent one per transaction
module csg_stamp_ser import csg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_stamp_load i_load,
    output logic        o_can_load,
    csg_out_if.source   o_out
);

    localparam int CharsW = StampChars * CharW;

    logic                r_busy;
    logic [IdxW-1:0]     r_idx;
    logic [CharsW-1:0]   r_chars;
    logic [CrcW-1:0]     r_crc;
    logic [CountW-1:0]   r_count;

    logic [CharsW-1:0]   n_chars;
    logic [CrcW+CountW-1:0] stamp;
    logic                last;
    logic                take;

    // convert every nibble of the stamp, most significant first
    always_comb begin
        stamp = {i_load.crc, i_load.count};
        for (int k = 0; k < StampChars; k++) begin
            n_chars[k*CharW +: CharW] = hex_char(stamp[k*NibbleW +: NibbleW]);
        end
    end

    assign last       = (r_idx == IdxW'(StampChars - 1));
    assign take       = r_busy && o_out.ready;
    assign o_can_load = !r_busy || (take && last);

    assign o_out.valid         = r_busy;
    assign o_out.stamp_char    = r_chars[CharsW-1 -: CharW];
    assign o_out.last_of_stamp = last;
    assign o_out.crc_value     = r_crc;
    assign o_out.byte_count    = r_count;

    // character position and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load.load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
            end
            r_idx <= r_idx + IdxW'(1);
        end
    end

    // character shift register and repeated sums
    always_ff @(posedge i_clk) begin
        if (i_load.load) begin
            r_chars <= n_chars;
            r_crc   <= i_load.crc;
            r_count <= i_load.count;
        end else if (take) begin
            r_chars <= r_chars << CharW;
        end
    end

endmodule

FILE: hdl/crc16_length_stamp_generator.sv
// CRC-16/ARC length stamp generator: one message byte per cycle in while no
// final byte stalls; after the final byte of a message, eight ASCII hex
// characters out (four digits of the CRC, then four of the saturated byte count,
// most significant first), one per transaction, with the CRC and count repeated
// on each. A byte can be taken in every cycle in which no final byte stalls,
// since the eight-bit CRC update fits between the input register and the running
// sums. A final byte waits in the input register until the serializer can load
// its stamp, and the first stamp character is offered from the serializer's
// character register after that load. The stamp serializer holds one stamp; the
// next message's bytes keep flowing while it drains, and a final byte stalls in
// the input register until the serializer hands out its eighth character.
module crc16_length_stamp_generator import csg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csg_in_if.sink    i_in,
    csg_out_if.source o_out
);

    t_stamp_load stamp_load;
    logic        can_load;

    // running crc and count
    csg_crc_acc u_crc_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_can_load (can_load),
        .o_load     (stamp_load)
    );

    // stamp character output
    csg_stamp_ser u_stamp_ser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (stamp_load),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

FILE: hdl/csg_checker.sv
// port-level assertions of the crc16 length stamp generator and their bind
`include "crc16_length_stamp_generator_assert.svh"

module csg_checker import csg_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [CharW-1:0]  i_stamp_char,
    input logic              i_last,
    input logic [CrcW-1:0]   i_crc,
    input logic [CountW-1:0] i_count
);

    // a stalled stamp transaction keeps its character
    `CSG_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_stamp_char) && $stable(i_last))

    // inside one stamp the characters follow each other and the sums stay put
    `CSG_ASSERT_NEXT(a_stamp_sums, i_out_valid && i_out_ready && !i_last, i_out_valid && $stable(i_crc) && $stable(i_count))

    // the eighth character is the low digit of the count
    `CSG_ASSERT(a_last_digit, !(i_out_valid && i_last) || (i_stamp_char == hex_char(i_count[NibbleW-1:0])))

    // every message holds at least its final byte
    `CSG_ASSERT(a_count_nonzero, !i_out_valid || (i_count != '0))

endmodule

bind crc16_length_stamp_generator csg_checker u_csg_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_stamp_char (o_out.stamp_char),
    .i_last       (o_out.last_of_stamp),
    .i_crc        (o_out.crc_value),
    .i_count      (o_out.byte_count)
);

FILE: tb/sv/tb_crc16_length_stamp_generator.sv
// testbench for the crc16 length stamp generator: byte stream in, hex stamp out
`timescale 1ns / 1ps

module tb_crc16_length_stamp_generator;
    import csg_pkg::*;

    // one pending message byte plus a flag that holds it until all stamps drained
    typedef struct packed {
        logic [DataW-1:0] data;
        logic             eom;
        logic             drain_first;
    } t_msg_byte;

    // one expected stamp character
    typedef struct packed {
        logic [CharW-1:0]  char_code;
        logic              last;
        logic [CrcW-1:0]   crc;
        logic [CountW-1:0] count;
    } t_stamp_char;

    localparam int MaxReports = 100;

    logic i_clk;
    logic i_rst_n;

    csg_in_if  in_bus ();
    csg_out_if out_bus ();

    crc16_length_stamp_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_msg_byte   send_q[$];
    t_stamp_char stamp_q[$];

    // running sums of the message in flight
    logic [CrcW-1:0]   msg_crc;
    logic [CountW-1:0] msg_len;

    bit          in_fire;
    int unsigned bytes_total;
    int unsigned bytes_taken;
    int unsigned msgs_done;
    int unsigned chars_checked;
    int unsigned longest_msg;
    int unsigned cur_msg_bytes;
    int unsigned errors;

    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned rx_cycle;
    t_msg_byte   next_byte;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // reflected crc-16 with poly 0xA001, data xored into the low byte first
    function automatic logic [CrcW-1:0] crc16_arc_byte(input logic [CrcW-1:0] crc,
                                                       input logic [DataW-1:0] b);
        logic [CrcW-1:0] r;
        r = crc ^ {{(CrcW-DataW){1'b0}}, b};
        for (int k = 0; k < DataW; k++) begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

    // uppercase ascii for one nibble
    function automatic logic [CharW-1:0] hex_ascii(input logic [NibbleW-1:0] nib);
        if (nib < NibbleW'(10)) begin
            return CharZero + CharW'(nib);
        end
        return CharA + CharW'(nib) - CharW'(10);
    endfunction

    // fold an accepted byte into the sums; a final byte queues its eight characters
    task automatic take_byte(input logic [DataW-1:0] b, input logic eom);
        logic [CrcW+CountW-1:0] stamp;
        t_stamp_char            sc;
        msg_crc = crc16_arc_byte(msg_crc, b);
        if (msg_len != CountMax) begin
            msg_len = msg_len + CountW'(1);
        end
        cur_msg_bytes++;
        bytes_taken++;
        if (eom) begin
            stamp = {msg_crc, msg_len};
            for (int k = 0; k < StampChars; k++) begin
                sc.char_code = hex_ascii(stamp[CrcW+CountW-1-NibbleW*k -: NibbleW]);
                sc.last      = (k == StampChars - 1);
                sc.crc       = msg_crc;
                sc.count     = msg_len;
                stamp_q.push_back(sc);
            end
            if (cur_msg_bytes > longest_msg) begin
                longest_msg = cur_msg_bytes;
            end
            cur_msg_bytes = 0;
            msgs_done++;
            msg_crc = CrcInit;
            msg_len = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MaxReports) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    task automatic add_byte(input logic [DataW-1:0] b, input logic eom, input logic drain);
        t_msg_byte mb;
        mb.data        = b;
        mb.eom         = eom;
        mb.drain_first = drain;
        send_q.push_back(mb);
    endtask

    // random content; some messages lean on 0x00 and 0xFF
    task automatic add_message(input int unsigned len, input bit drain);
        bit               edgy;
        logic [DataW-1:0] b;
        edgy = ($urandom_range(0, 4) == 0);
        for (int unsigned k = 0; k < len; k++) begin
            b = DataW'($urandom);
            if (edgy && $urandom_range(0, 1) == 0) begin
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            add_byte(b, k == len - 1, drain && k == 0);
        end
    endtask

    // input monitor, predictor and output checker
    always @(posedge i_clk) begin
        t_stamp_char want;
        in_fire = i_rst_n && in_bus.valid && in_bus.ready;
        if (in_fire) begin
            take_byte(in_bus.data_byte, in_bus.end_of_message);
        end
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (stamp_q.size() == 0) begin
                errors++;
                if (errors <= MaxReports) begin
                    $display("%0t: unexpected stamp transaction, expected none, got char %h",
                             $time, out_bus.stamp_char);
                end
            end else begin
                want = stamp_q.pop_front();
                check_field("stamp_char", 32'(want.char_code), 32'(out_bus.stamp_char));
                check_field("last_of_stamp", 32'(want.last), 32'(out_bus.last_of_stamp));
                check_field("crc_value", 32'(want.crc), 32'(out_bus.crc_value));
                check_field("byte_count", 32'(want.count), 32'(out_bus.byte_count));
                chars_checked++;
            end
        end
    end

    // byte driver: bursts with random gaps, optional hold until stamps drained
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else if (!in_bus.valid || in_fire) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left != 0) begin
                gap_left--;
                in_bus.valid <= 1'b0;
            end else if (send_q.size() == 0 ||
                         (send_q[0].drain_first && stamp_q.size() != 0)) begin
                in_bus.valid <= 1'b0;
            end else begin
                next_byte = send_q.pop_front();
                burst_left--;
                in_bus.valid          <= 1'b1;
                in_bus.data_byte      <= next_byte.data;
                in_bus.end_of_message <= next_byte.eom;
            end
        end
    end

    // stamp receiver: ready pattern switches style with bits 8:7 of the cycle counter
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (stall_left != 0) begin
                stall_left--;
                out_bus.ready <= 1'b0;
            end else begin
                case (rx_cycle[8:7])
                    2'd0: begin
                        out_bus.ready <= 1'b1;
                    end
                    2'd1: begin
                        out_bus.ready <= 1'($urandom_range(0, 1));
                    end
                    2'd2: begin
                        if ($urandom_range(0, 9) == 0) begin
                            stall_left = $urandom_range(1, 11);
                            out_bus.ready <= 1'b0;
                        end else begin
                            out_bus.ready <= 1'b1;
                        end
                    end
                    default: begin
                        out_bus.ready <= (rx_cycle % 3 != 0);
                    end
                endcase
            end
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned random_bytes;
        int unsigned len;
        in_bus.valid          = 1'b0;
        in_bus.data_byte      = '0;
        in_bus.end_of_message = 1'b0;
        out_bus.ready         = 1'b0;
        i_rst_n               = 1'b0;
        msg_crc               = CrcInit;
        msg_len               = '0;

        // directed: one-byte messages at both extremes of the byte
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        // standard check string "123456789"
        for (int k = 1; k <= 9; k++) begin
            add_byte(DataW'(CharZero) + DataW'(k), k == 9, 1'b0);
        end
        // zero bytes in the middle are data, not terminators
        add_byte(8'h00, 1'b0, 1'b1);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(8'h01, 1'b1, 1'b0);
        // back-to-back single-byte messages
        add_byte(8'h55, 1'b1, 1'b0);
        add_byte(8'hAA, 1'b1, 1'b0);

        // short message after a full drain
        add_message(3, 1'b1);

        // random messages, mostly short with a few longer ones
        random_bytes = 0;
        while (random_bytes < 220) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 10);
            add_message(len, $urandom_range(0, 7) == 0);
            random_bytes += len;
        end
        bytes_total = send_q.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (bytes_taken != bytes_total) @(posedge i_clk);
        while (stamp_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("covered %0d messages (%0d bytes, longest %0d) and %0d stamp characters",
                 msgs_done, bytes_taken, longest_msg, chars_checked);
        $display("mismatching fields or stray transactions: %0d", errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("timeout with %0d stamp characters outstanding", stamp_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
